// File: hw/rtl/sdds_pkg.sv
package sdds_pkg;

  localparam int SDDS_PHASE_BITS     = 32;
  localparam int SDDS_TABLE_ADDR_BITS = 10;
  localparam int SDDS_SAMPLE_RATE    = 4000;
  localparam int SDDS_DAC_BITS       = 12;

  localparam int FREQ_BITS      = 18;
  localparam int AMP_BITS       = 10;
  localparam int CFG_DATA_BITS  = 18;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FREQUENCY = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE = 1'b1;

  localparam logic [FREQ_BITS-1:0] FREQ_RESET = 18'd1000;
  localparam logic [AMP_BITS-1:0]  AMP_RESET  = 10'd100;

  // Width of one operand of the shared serial multiplier.
  localparam int MUL_BITS = 32;

  localparam logic [MUL_BITS-1:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [30:0]         ONE_Q30     = 31'h4000_0000;
  localparam int                  VREF_CENTIVOLTS = 330;
  localparam logic [16:0]         SINE_OFFSET = 17'd32768;

  // Odd Taylor terms from x^3 up to x^13.
  localparam int TERMS = 6;
  localparam int TERM_IDX_BITS = 3;

  typedef enum logic [0:0] {
    OP_MUL,
    OP_DIV
  } sdds_op_t;

  typedef struct packed {
    logic     start;
    sdds_op_t op;
  } sdds_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_STEP_DIV,
    ST_STEP_WAIT,
    ST_PHASE,
    ST_X_MUL,
    ST_X_WAIT,
    ST_X2_MUL,
    ST_X2_WAIT,
    ST_T_MUL,
    ST_T_MUL_WAIT,
    ST_T_DIV,
    ST_T_DIV_WAIT,
    ST_ROUND,
    ST_AMP_MUL,
    ST_AMP_WAIT,
    ST_SCALE_DIV,
    ST_SCALE_WAIT,
    ST_OUT
  } sdds_state_t;

  // Denominator (n-1)*n of the Taylor term x^n, with n = 2k+3.
  function automatic logic [7:0] term_divisor(input logic [TERM_IDX_BITS-1:0] k);
    logic [7:0] d;
    unique case (k)
      3'd0: d = 8'd6;
      3'd1: d = 8'd20;
      3'd2: d = 8'd42;
      3'd3: d = 8'd72;
      3'd4: d = 8'd110;
      3'd5: d = 8'd156;
      default: d = 8'd156;
    endcase
    return d;
  endfunction

endpackage

// File: hw/rtl/sdds_serial_unit.sv
module sdds_serial_unit
  import sdds_pkg::*;
#(
  parameter int W   = 64,
  parameter int DVW = 19
) (
  input  logic                clk,
  input  logic                rst,
  input  sdds_req_t           req,
  input  logic [W-1:0]        opa,
  input  logic [MUL_BITS-1:0] opb,
  output logic                done,
  output logic [W-1:0]        result
);

  localparam int CW = $clog2(W + 1);

  logic                busy;
  sdds_op_t            op_q;
  logic [CW-1:0]       cnt;
  logic [MUL_BITS-1:0] mcand;
  logic [MUL_BITS-1:0] hi;
  logic [W-1:0]        lo;
  logic [DVW-1:0]      rem;

  logic [MUL_BITS:0]   mul_sum;
  logic [DVW:0]        div_shift;
  logic [DVW:0]        div_diff;
  logic                div_ge;

  // Multiply: one multiplier bit per cycle, LSB first, product shifting right into lo.
  // Divide: one quotient bit per cycle, dividend shifting left out of lo.
  always_comb begin
    mul_sum   = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : {(MUL_BITS + 1){1'b0}});
    div_shift = {rem, lo[W-1]};
    div_diff  = div_shift - {1'b0, mcand[DVW-1:0]};
    div_ge    = div_shift >= {1'b0, mcand[DVW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op_q <= OP_MUL;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        op_q  <= req.op;
        mcand <= opb;
        lo    <= opa;
        hi    <= '0;
        rem   <= '0;
        cnt   <= (req.op == OP_MUL) ? CW'(MUL_BITS) : CW'(W);
      end else if (busy) begin
        unique case (op_q)
          OP_MUL: begin
            hi              <= mul_sum[MUL_BITS:1];
            lo[MUL_BITS-1:0] <= {mul_sum[0], lo[MUL_BITS-1:1]};
          end
          OP_DIV: begin
            rem <= div_ge ? div_diff[DVW-1:0] : div_shift[DVW-1:0];
            lo  <= {lo[W-2:0], div_ge};
          end
        endcase
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The result holds until the next start.
  always_comb begin
    unique case (op_q)
      OP_MUL: result = W'({hi, lo[MUL_BITS-1:0]});
      OP_DIV: result = lo;
    endcase
  end

endmodule

// File: hw/rtl/sine_dds_dac_generator.sv
// An accepted tick of 1 yields one DAC code; W = max(2*MUL_BITS, PHASE_BITS+19).
// All work goes through one shared bit-serial unit: eight divisions of W steps and nine
// multiplies of 32 steps. One tick is in work at a time, so a tick of 1 is not taken
// again until the code of the last one has gone to the output register; a full output
// register holds the block until it drains. A tick of 0 is taken whenever the block is idle.
// Synchronous reset clears the phase, restores the register defaults and empties the output.
module sine_dds_dac_generator
  import sdds_pkg::*;
#(
  parameter int PHASE_BITS           = SDDS_PHASE_BITS,
  parameter int SINE_TABLE_ADDR_BITS = SDDS_TABLE_ADDR_BITS,
  parameter int SAMPLE_RATE          = SDDS_SAMPLE_RATE,
  parameter int DAC_BITS             = SDDS_DAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      tick,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [DAC_BITS-1:0]       dac_code
);

  localparam int A       = SINE_TABLE_ADDR_BITS;
  localparam int DIVISOR = 100 * SAMPLE_RATE;
  localparam int DVW_RAW = $clog2(DIVISOR + 1);
  localparam int DVW     = (DVW_RAW > 9) ? DVW_RAW : 9;
  localparam int W       = (2 * MUL_BITS > FREQ_BITS + PHASE_BITS + 1) ?
                           2 * MUL_BITS : FREQ_BITS + PHASE_BITS + 1;
  localparam int N1W     = 17 + AMP_BITS;
  localparam int NW      = N1W + DAC_BITS;
  localparam logic [A-2:0]        QUARTER  = {1'b1, {(A - 2){1'b0}}};
  localparam logic [DAC_BITS-1:0] DAC_FULL = '1;

  sdds_state_t state, state_next;

  logic [FREQ_BITS-1:0]     freq;
  logic [AMP_BITS-1:0]      amp;
  logic [PHASE_BITS-1:0]    phase;
  logic [PHASE_BITS-1:0]    step;
  logic [MUL_BITS-1:0]      x;
  logic [MUL_BITS-1:0]      x2;
  logic [MUL_BITS-1:0]      term;
  logic signed [33:0]       sum;
  logic [TERM_IDX_BITS-1:0] k;
  logic [16:0]              u;
  logic [NW-17:0]           scaled;

  sdds_req_t           req;
  logic [W-1:0]        opa;
  logic [MUL_BITS-1:0] opb;
  logic                done;
  logic [W-1:0]        res;

  logic [1:0]      quad;
  logic [A-2:0]    m;
  logic [PHASE_BITS:0] step_round;
  logic [30:0]     clamped;
  logic [31:0]     rounded;
  logic [15:0]     mag;
  logic [NW-1:0]   n1_ext;
  logic [NW-1:0]   n_full;
  logic            out_free;

  sdds_serial_unit #(
    .W   (W),
    .DVW (DVW)
  ) u_unit (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .opa    (opa),
    .opb    (opb),
    .done   (done),
    .result (res)
  );

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    quad       = phase[PHASE_BITS-1 -: 2];
    m          = quad[0] ? QUARTER - {1'b0, phase[PHASE_BITS-3 -: A-2]}
                         : {1'b0, phase[PHASE_BITS-3 -: A-2]};
    step_round = res[PHASE_BITS:0] + 1'b1;
    if (sum[33]) begin
      clamped = '0;
    end else if (sum > $signed({3'b000, ONE_Q30})) begin
      clamped = ONE_Q30;
    end else begin
      clamped = sum[30:0];
    end
    rounded = {1'b0, clamped} + 32'h0000_4000;
    mag     = rounded[30:15];
    n1_ext  = NW'(res[N1W-1:0]);
    n_full  = (n1_ext << DAC_BITS) - n1_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.start  = 1'b0;
    req.op     = OP_MUL;
    opa        = '0;
    opb        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && tick) begin
          state_next = ST_STEP_DIV;
        end
      end
      ST_STEP_DIV: begin
        req.start  = 1'b1;
        req.op     = OP_DIV;
        opa        = W'(freq) << (PHASE_BITS + 1);
        opb        = MUL_BITS'(DIVISOR);
        state_next = ST_STEP_WAIT;
      end
      ST_STEP_WAIT: if (done) state_next = ST_PHASE;
      ST_PHASE:     state_next = ST_X_MUL;
      ST_X_MUL: begin
        req.start  = 1'b1;
        opa        = W'(m);
        opb        = HALF_PI_Q30;
        state_next = ST_X_WAIT;
      end
      ST_X_WAIT: if (done) state_next = ST_X2_MUL;
      ST_X2_MUL: begin
        req.start  = 1'b1;
        opa        = W'(x);
        opb        = x;
        state_next = ST_X2_WAIT;
      end
      ST_X2_WAIT: if (done) state_next = ST_T_MUL;
      ST_T_MUL: begin
        req.start  = 1'b1;
        opa        = W'(x2);
        opb        = term;
        state_next = ST_T_MUL_WAIT;
      end
      ST_T_MUL_WAIT: if (done) state_next = ST_T_DIV;
      ST_T_DIV: begin
        // The product still stands in the unit and is loaded back as the dividend.
        req.start  = 1'b1;
        req.op     = OP_DIV;
        opa        = res >> 30;
        opb        = MUL_BITS'(term_divisor(k));
        state_next = ST_T_DIV_WAIT;
      end
      ST_T_DIV_WAIT: begin
        if (done) begin
          state_next = (k == TERM_IDX_BITS'(TERMS - 1)) ? ST_ROUND : ST_T_MUL;
        end
      end
      ST_ROUND: state_next = ST_AMP_MUL;
      ST_AMP_MUL: begin
        req.start  = 1'b1;
        opa        = W'(amp);
        opb        = MUL_BITS'(u);
        state_next = ST_AMP_WAIT;
      end
      ST_AMP_WAIT: if (done) state_next = ST_SCALE_DIV;
      ST_SCALE_DIV: begin
        req.start  = 1'b1;
        req.op     = OP_DIV;
        opa        = W'(scaled);
        opb        = MUL_BITS'(VREF_CENTIVOLTS);
        state_next = ST_SCALE_WAIT;
      end
      ST_SCALE_WAIT: if (done) state_next = ST_OUT;
      ST_OUT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freq  <= FREQ_RESET;
      amp   <= AMP_RESET;
      phase <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FREQUENCY: freq <= cfg_data[FREQ_BITS-1:0];
          REG_AMPLITUDE: amp  <= cfg_data[AMP_BITS-1:0];
        endcase
      end
      if (state == ST_PHASE) begin
        phase <= phase + step;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_STEP_WAIT: if (done) step <= step_round[PHASE_BITS:1];
      ST_X_WAIT:    if (done) x <= MUL_BITS'(res >> (A - 2));
      ST_X2_WAIT: begin
        if (done) begin
          x2   <= MUL_BITS'(res >> 30);
          term <= x;
          sum  <= $signed({2'b00, x});
          k    <= '0;
        end
      end
      ST_T_DIV_WAIT: begin
        if (done) begin
          term <= res[MUL_BITS-1:0];
          // Terms alternate in sign, starting with a subtraction of the cubic term.
          if (k[0]) begin
            sum <= sum + $signed({2'b00, res[MUL_BITS-1:0]});
          end else begin
            sum <= sum - $signed({2'b00, res[MUL_BITS-1:0]});
          end
          k <= k + 1'b1;
        end
      end
      ST_ROUND:    u <= quad[1] ? SINE_OFFSET - 17'(mag) : SINE_OFFSET + 17'(mag);
      ST_AMP_WAIT: if (done) scaled <= n_full[NW-1:16];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
      dac_code  <= (res > W'(DAC_FULL)) ? DAC_FULL : res[DAC_BITS-1:0];
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
